// ----- design/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int FIELD_W = 16;
  localparam int TIME_W  = 32;
  localparam int SUM_W   = 40;
  localparam int CNT_CFG_W = 5;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // what the front end makes of an item
  typedef enum logic [1:0] {
    K_NOP   = 2'd0,
    K_LOAD  = 2'd1,
    K_TICK  = 2'd2,
    K_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] priority_req;
  } qent_t;

  // one task slot as held in the task memory
  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] rem;
  } task_ent_t;

  typedef struct packed {
    logic [SLOT_W-1:0] selected;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
  } result_t;

  // front end to back end
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } fe_out_t;

endpackage

// ----- design/pps_front.sv -----
// ----------------------------------------------------------------------------
// pps_front
// Accepts items, classifies the command and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pps_front import pps_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [FIELD_W-1:0] in_arrival,
  input  logic [FIELD_W-1:0] in_burst,
  input  logic [FIELD_W-1:0] in_priority_req,
  output fe_out_t            fe_out,
  input  logic               fe_pop
);

  qent_t       q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  qent_t       ent_in;

  // loads aimed beyond the slots that exist write nothing
  always_comb begin
    ent_in.slot         = in_slot;
    ent_in.arrival      = in_arrival;
    ent_in.burst        = in_burst;
    ent_in.priority_req = in_priority_req;
    case (in_command)
      CMD_LOAD:  ent_in.kind = (32'(in_slot) < 32'(MAX_TASKS)) ? K_LOAD : K_NOP;
      CMD_TICK:  ent_in.kind = K_TICK;
      CMD_CLEAR: ent_in.kind = K_CLEAR;
      default:   ent_in.kind = K_NOP;
    endcase
  end

  assign in_ready     = (count_r != 2'd2);
  assign push         = in_valid && in_ready;
  assign fe_out.valid = (count_r != 2'd0);
  assign fe_out.ent   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = fe_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(fe_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent_in;
    end
  end

endmodule

// ----- design/pps_exec.sv -----
// ----------------------------------------------------------------------------
// pps_exec
// Back end: task memory, slot scan, tick update and result register.
// ----------------------------------------------------------------------------
module pps_exec import pps_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CNT_CFG_W-1:0] cfg_wdata,
  input  fe_out_t              fe_out,
  output logic                 fe_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_res
);

  localparam int IDX_W = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_CFG_W-1:0] task_count_r;
  logic [CNT_W-1:0]     n_use;
  logic [MAX_TASKS-1:0] use_mask;
  logic [MAX_TASKS-1:0] nz_r, nz_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic [SUM_W-1:0]     wsum_r, wsum_nxt, tsum_r, tsum_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  task_ent_t            best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              res_r, res_nxt;

  task_ent_t            task_mem [MAX_TASKS];
  task_ent_t            rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  task_ent_t            wr_data;

  logic                 all_done_now;
  logic                 emit;
  logic                 cand;
  logic [TIME_W-1:0]    end_time;
  logic [FIELD_W-1:0]   rem_dec;
  logic [SUM_W:0]       wsum_add, tsum_add;
  logic [SLOT_W-1:0]    r_sel;
  logic                 r_idle, r_fin;
  logic [TIME_W-1:0]    r_ft, r_tat, r_wt;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    if (32'(task_count_r) > 32'(MAX_TASKS)) begin
      n_use = CNT_W'(MAX_TASKS);
    end else begin
      n_use = CNT_W'(task_count_r);
    end
    for (int k = 0; k < MAX_TASKS; k++) begin
      use_mask[k] = (CNT_W'(k) < n_use);
    end
  end

  assign all_done_now = ~|(nz_r & use_mask);
  assign rd_addr      = scan_idx_r[IDX_W-1:0];
  assign end_time     = time_r + 32'd1;
  assign rem_dec      = best_r.rem - 16'd1;
  assign cand         = chk_valid_r && nz_r[chk_idx_r] &&
                        (32'(rd_data_r.arrival) <= time_r) &&
                        (!found_r || (rd_data_r.prio < best_r.prio));

  always_comb begin
    state_nxt     = state_r;
    nz_nxt        = nz_r;
    time_nxt      = time_r;
    wsum_nxt      = wsum_r;
    tsum_nxt      = tsum_r;
    scan_idx_nxt  = scan_idx_r;
    chk_valid_nxt = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fe_pop        = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = best_idx_r;
    wr_data       = best_r;
    emit          = 1'b0;
    r_sel         = '0;
    r_idle        = 1'b1;
    r_fin         = 1'b0;
    r_ft          = '0;
    r_tat         = '0;
    r_wt          = '0;
    wsum_add      = '0;
    tsum_add      = '0;

    case (state_r)
      ST_IDLE: begin
        // only take an item once the result register is free for it
        if (fe_out.valid && (!out_valid_r || out_ready)) begin
          fe_pop = 1'b1;
          case (fe_out.ent.kind)
            K_LOAD: begin
              wr_en           = 1'b1;
              wr_addr         = IDX_W'(fe_out.ent.slot);
              wr_data.arrival = fe_out.ent.arrival;
              wr_data.burst   = fe_out.ent.burst;
              wr_data.prio    = fe_out.ent.priority_req;
              wr_data.rem     = fe_out.ent.burst;
              nz_nxt[IDX_W'(fe_out.ent.slot)] = (fe_out.ent.burst != '0);
              emit            = 1'b1;
            end
            K_TICK: begin
              if (all_done_now) begin
                emit = 1'b1;
              end else begin
                state_nxt    = ST_SCAN;
                scan_idx_nxt = '0;
                found_nxt    = 1'b0;
              end
            end
            K_CLEAR: begin
              time_nxt = '0;
              wsum_nxt = '0;
              tsum_nxt = '0;
              emit     = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // one slot read per cycle, compared in the next cycle
        if (cand) begin
          found_nxt    = 1'b1;
          best_idx_nxt = chk_idx_r;
          best_nxt     = rd_data_r;
        end
        if (scan_idx_r < n_use) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        end else begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        if (found_r) begin
          wr_en       = 1'b1;
          wr_addr     = best_idx_r;
          wr_data.rem = rem_dec;
          r_sel       = SLOT_W'(best_idx_r);
          r_idle      = 1'b0;
          if (rem_dec == '0) begin
            nz_nxt[best_idx_r] = 1'b0;
            r_fin    = 1'b1;
            r_ft     = end_time;
            r_tat    = end_time - 32'(best_r.arrival);
            r_wt     = r_tat - 32'(best_r.burst);
            wsum_add = {1'b0, wsum_r} + 41'(r_wt);
            tsum_add = {1'b0, tsum_r} + 41'(r_tat);
            wsum_nxt = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
            tsum_nxt = tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
          end
        end
        time_nxt  = end_time;
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res_nxt = res_r;
    if (emit) begin
      out_valid_nxt            = 1'b1;
      res_nxt.selected         = r_sel;
      res_nxt.idle             = r_idle;
      res_nxt.finished         = r_fin;
      res_nxt.finish_time      = r_ft;
      res_nxt.turnaround       = r_tat;
      res_nxt.waiting          = r_wt;
      res_nxt.all_done         = ~|(nz_nxt & use_mask);
      res_nxt.total_waiting    = wsum_nxt;
      res_nxt.total_turnaround = tsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= CNT_CFG_W'(1);
      nz_r         <= '0;
      time_r       <= '0;
      wsum_r       <= '0;
      tsum_r       <= '0;
      chk_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        task_count_r <= cfg_wdata;
      end
      nz_r         <= nz_nxt;
      time_r       <= time_nxt;
      wsum_r       <= wsum_nxt;
      tsum_r       <= tsum_nxt;
      chk_valid_r  <= chk_valid_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
  end

  // task memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      task_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= task_mem[rd_addr];
  end

endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Priority task scheduler: loads task slots and runs one tick per tick item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_*      input      in_valid/in_ready    command, slot, arrival, burst,
//                                            priority_req
//  out_*     output     out_valid/out_ready  selected .. total_turnaround
//  cfg_*     input      cfg_we (no wait)     cfg_wdata = task_count
//
//  Load, clear and no-op items are handled in ST_IDLE; a tick scans the n
//  slots in use one slot per cycle in ST_SCAN, then writes back in ST_UPDATE;
//  a tick with every slot done skips the scan and is answered from ST_IDLE.
//  A two-entry queue keeps accepting items while the back end works or a
//  result waits. Synchronous reset clears time, sums and remaining work;
//  task_count resets to 1.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [FIELD_W-1:0]   in_arrival,
  input  logic [FIELD_W-1:0]   in_burst,
  input  logic [FIELD_W-1:0]   in_priority_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SLOT_W-1:0]    out_selected,
  output logic                 out_idle,
  output logic                 out_finished,
  output logic [TIME_W-1:0]    out_finish_time,
  output logic [TIME_W-1:0]    out_turnaround,
  output logic [TIME_W-1:0]    out_waiting,
  output logic                 out_all_done,
  output logic [SUM_W-1:0]     out_total_waiting,
  output logic [SUM_W-1:0]     out_total_turnaround,
  input  logic                 cfg_we,
  input  logic [CNT_CFG_W-1:0] cfg_wdata
);

  fe_out_t fe_out;
  logic    fe_pop;
  result_t res;

  pps_front #(
    .MAX_TASKS (MAX_TASKS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_slot         (in_slot),
    .in_arrival      (in_arrival),
    .in_burst        (in_burst),
    .in_priority_req (in_priority_req),
    .fe_out          (fe_out),
    .fe_pop          (fe_pop)
  );

  pps_exec #(
    .MAX_TASKS (MAX_TASKS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fe_out    (fe_out),
    .fe_pop    (fe_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_selected         = res.selected;
  assign out_idle             = res.idle;
  assign out_finished         = res.finished;
  assign out_finish_time      = res.finish_time;
  assign out_turnaround       = res.turnaround;
  assign out_waiting          = res.waiting;
  assign out_all_done         = res.all_done;
  assign out_total_waiting    = res.total_waiting;
  assign out_total_turnaround = res.total_turnaround;

`ifndef SYNTHESIS
  // an idle result never reports a completion or a slot
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_idle) |-> (!out_finished && (out_selected == '0)))
    else $error("idle result carries a slot or a completion");

  // back end pops only what the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fe_pop |-> fe_out.valid)
    else $error("pop from an empty queue");

  // a full queue means the back end has work waiting
  a_full_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> fe_out.valid)
    else $error("input stalled with nothing queued");
`endif

endmodule

// ----- bench/preemptive_priority_scheduler_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// Self-checking bench for the priority task scheduler. Directed items cover
// zero bursts, task counts of zero and beyond the slot count, preemption,
// priority ties, idle ticks and clear; random phases then run well-formed
// task sets with reloads and noise under several task counts. Every result
// is compared field by field against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_test;
  import pps_pkg::*;

  localparam int                NUM_SLOTS   = 16;
  localparam int                CYCLE_LIMIT = 600000;
  localparam int                PRINT_LIMIT = 40;
  localparam logic [CMD_W-1:0]  CMD_SPARE   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] prio;
  } sched_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command = CMD_LOAD;
  logic [SLOT_W-1:0]    in_slot = '0;
  logic [FIELD_W-1:0]   in_arrival = '0;
  logic [FIELD_W-1:0]   in_burst = '0;
  logic [FIELD_W-1:0]   in_priority_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SLOT_W-1:0]    out_selected;
  logic                 out_idle;
  logic                 out_finished;
  logic [TIME_W-1:0]    out_finish_time;
  logic [TIME_W-1:0]    out_turnaround;
  logic [TIME_W-1:0]    out_waiting;
  logic                 out_all_done;
  logic [SUM_W-1:0]     out_total_waiting;
  logic [SUM_W-1:0]     out_total_turnaround;
  logic                 cfg_we = 1'b0;
  logic [CNT_CFG_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [FIELD_W-1:0]   task_arrival [NUM_SLOTS];
  logic [FIELD_W-1:0]   task_burst [NUM_SLOTS];
  logic [FIELD_W-1:0]   task_prio [NUM_SLOTS];
  logic [FIELD_W-1:0]   task_left [NUM_SLOTS];
  logic [TIME_W-1:0]    sched_clock = '0;
  logic [SUM_W-1:0]     sum_waiting = '0;
  logic [SUM_W-1:0]     turnaround_acc = '0;
  logic [CNT_CFG_W-1:0] slots_used = 5'd1;

  sched_item_t          send_queue [$];
  result_t              expected_results [$];
  int                   mismatch_count = 0;
  int                   results_seen = 0;
  int                   cycle_count = 0;
  int                   in_gap_left = 0;
  int                   out_stall_left = 0;
  bit                   idling_on = 1'b1;

  preemptive_priority_scheduler dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_slot              (in_slot),
    .in_arrival           (in_arrival),
    .in_burst             (in_burst),
    .in_priority_req      (in_priority_req),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_selected         (out_selected),
    .out_idle             (out_idle),
    .out_finished         (out_finished),
    .out_finish_time      (out_finish_time),
    .out_turnaround       (out_turnaround),
    .out_waiting          (out_waiting),
    .out_all_done         (out_all_done),
    .out_total_waiting    (out_total_waiting),
    .out_total_turnaround (out_total_turnaround),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int active_slots();
    return (slots_used > NUM_SLOTS) ? NUM_SLOTS : int'(slots_used);
  endfunction

  function automatic bit all_slots_finished();
    for (int k = 0; k < active_slots(); k++)
      if (task_left[k] != '0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [TIME_W-1:0] add);
    logic [SUM_W:0] total;
    total = {1'b0, acc} + add;
    return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
  endfunction

  function automatic result_t schedule_step(sched_item_t it);
    result_t           r;
    int                best;
    bit                found;
    logic [TIME_W-1:0] done_at;
    logic [TIME_W-1:0] tat;
    r = '0;
    r.idle = 1'b1;
    best = 0;
    found = 1'b0;
    case (it.command)
      CMD_LOAD: begin
        task_arrival[it.slot] = it.arrival;
        task_burst[it.slot]   = it.burst;
        task_prio[it.slot]    = it.prio;
        task_left[it.slot]    = it.burst;
      end
      CMD_CLEAR: begin
        sched_clock    = '0;
        sum_waiting    = '0;
        turnaround_acc = '0;
      end
      CMD_TICK: begin
        if (!all_slots_finished()) begin
          for (int k = 0; k < active_slots(); k++) begin
            if (task_left[k] != '0 && TIME_W'(task_arrival[k]) <= sched_clock &&
                (!found || task_prio[k] < task_prio[best])) begin
              best  = k;
              found = 1'b1;
            end
          end
          if (found) begin
            done_at         = sched_clock + 1;
            r.selected      = SLOT_W'(best);
            r.idle          = 1'b0;
            task_left[best] = task_left[best] - 1'b1;
            if (task_left[best] == '0) begin
              tat            = done_at - TIME_W'(task_arrival[best]);
              r.finished     = 1'b1;
              r.finish_time  = done_at;
              r.turnaround   = tat;
              r.waiting      = tat - TIME_W'(task_burst[best]);
              sum_waiting    = sat_sum(sum_waiting, r.waiting);
              turnaround_acc = sat_sum(turnaround_acc, tat);
            end
          end
          sched_clock = sched_clock + 1;
        end
      end
      default: ;
    endcase
    r.all_done         = all_slots_finished();
    r.total_waiting    = sum_waiting;
    r.total_turnaround = turnaround_acc;
    return r;
  endfunction

  initial begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      task_arrival[k] = '0;
      task_burst[k]   = '0;
      task_prio[k]    = '0;
      task_left[k]    = '0;
    end
  end

  // ------------------------------------------------------------ input driver

  always @(posedge clk) begin : drive_items
    sched_item_t taken;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken = send_queue.pop_front();
        expected_results.push_back(schedule_step(taken));
        if (idling_on && $urandom_range(0, 4) == 0) in_gap_left = $urandom_range(1, 13);
      end
      if (in_valid && !in_ready) begin
        // hold: item not yet taken
      end else if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (send_queue.size() != 0) begin
        in_valid        <= 1'b1;
        in_command      <= send_queue[0].command;
        in_slot         <= send_queue[0].slot;
        in_arrival      <= send_queue[0].arrival;
        in_burst        <= send_queue[0].burst;
        in_priority_req <= send_queue[0].prio;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ----------------------------------------------------------------- checker

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(string name, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("selected", out_selected, want.selected);
        check_field("idle", out_idle, want.idle);
        check_field("finished", out_finished, want.finished);
        check_field("finish_time", out_finish_time, want.finish_time);
        check_field("turnaround", out_turnaround, want.turnaround);
        check_field("waiting", out_waiting, want.waiting);
        check_field("all_done", out_all_done, want.all_done);
        check_field("total_waiting", out_total_waiting, want.total_waiting);
        check_field("total_turnaround", out_total_turnaround, want.total_turnaround);
      end
      results_seen++;
    end
  end

  // ------------------------------------------------------------- stimulus

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                           logic [FIELD_W-1:0] arrival, logic [FIELD_W-1:0] burst,
                           logic [FIELD_W-1:0] prio);
    sched_item_t it;
    it = '{cmd, slot, arrival, burst, prio};
    do @(negedge clk); while (send_queue.size() >= 2);
    send_queue.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (send_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_task_count(logic [CNT_CFG_W-1:0] count);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= count;
    slots_used  = count;
    @(posedge clk);
    cfg_we     <= 1'b0;
  endtask

  task automatic test_reset_state();
    // reset count of one, slot 0 empty: the tick finds everything done
    send_item(CMD_TICK, '0, '0, '0, '0);
    send_item(CMD_SPARE, 4'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_zero_burst();
    // writes every slot with nothing to do, so the scan never sees stale entries
    for (int s = 0; s < NUM_SLOTS; s++)
      send_item(CMD_LOAD, SLOT_W'(s), (s % 2) ? 16'hFFFF : 16'h0000, '0,
                (s % 2) ? 16'h0000 : 16'hFFFF);
    send_item(CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_task_count_limits();
    write_task_count(5'd0);
    send_item(CMD_TICK, '0, '0, '0, '0);
    write_task_count(5'd31);
    send_item(CMD_LOAD, 4'd15, 16'd0, 16'd2, 16'd7);
    repeat (3) send_item(CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_preemption();
    write_task_count(5'd3);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_LOAD, 4'd0, 16'd0, 16'd3, 16'd5);
    send_item(CMD_LOAD, 4'd1, 16'd1, 16'd1, 16'd0);
    send_item(CMD_LOAD, 4'd2, 16'd0, 16'd1, 16'd5);   // ties slot 0, loses on index
    repeat (6) send_item(CMD_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_idle_and_clear();
    write_task_count(5'd1);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_LOAD, 4'd0, 16'd2, 16'd1, 16'hFFFF);
    repeat (3) send_item(CMD_TICK, '0, '0, '0, '0);
    send_item(CMD_LOAD, 4'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_item(CMD_TICK, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_LOAD, 4'd0, 16'd0, 16'd0, 16'd0);
  endtask

  task automatic send_random_load(int span);
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] prio;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      arrival = (sched_clock > 32'd65000) ? 16'hFFFF
                : FIELD_W'(sched_clock + $urandom_range(0, 10)) - FIELD_W'($urandom_range(0, 6));
      if (arrival > FIELD_W'(sched_clock + 10)) arrival = '0;
    end else begin
      arrival = FIELD_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 85)      burst = FIELD_W'($urandom_range(1, 6));
    else if (pick < 95) burst = '0;
    else                burst = FIELD_W'($urandom);
    prio = ($urandom_range(0, 2) == 0) ? FIELD_W'($urandom_range(0, 3)) : FIELD_W'($urandom);
    send_item(CMD_LOAD, SLOT_W'($urandom_range(0, span - 1)), arrival, burst, prio);
  endtask

  task automatic test_random_schedule();
    int counts [10] = '{2, 16, 1, 31, 5, 17, 0, 9, 16, 4};
    int span;
    int pick;
    for (int p = 0; p < 10; p++) begin
      idling_on = (p < 8);
      write_task_count(CNT_CFG_W'(counts[p]));
      span = (counts[p] == 0 || counts[p] > NUM_SLOTS) ? NUM_SLOTS : counts[p];
      send_item(CMD_CLEAR, '0, '0, '0, '0);
      for (int s = 0; s < span; s++) send_random_load(s + 1);
      for (int i = 0; i < 110; i++) begin
        if (p < 8 && i % 30 == 0) idling_on = $urandom_range(0, 1);
        if (p == 3 && i == 60) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 64)      send_item(CMD_TICK, '0, '0, '0, '0);
        else if (pick < 90) send_random_load(span);
        else if (pick < 93) send_item(CMD_CLEAR, '0, '0, '0, '0);
        else if (pick < 96) send_item(CMD_SPARE, SLOT_W'($urandom), FIELD_W'($urandom),
                                      FIELD_W'($urandom), FIELD_W'($urandom));
        else                send_random_load(NUM_SLOTS);   // may land outside the count
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_zero_burst();
    test_task_count_limits();
    test_preemption();
    test_idle_and_clear();
    test_random_schedule();
    idling_on = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
